// ----- sv/lls_pkg.sv -----
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types, constants and saturating arithmetic for the LIFO load shedder.
// ----------------------------------------------------------------------------
package lls_pkg;

    // field widths
    localparam int ID_W     = 3;
    localparam int POWER_W  = 17;
    localparam int TOTAL_W  = 21;
    localparam int LIMIT_W  = 19;
    localparam int EV_W     = 3;

    // defaults and limits
    localparam int DEVICES_DEFAULT = 8;
    localparam int RESULT_CAP      = 32;
    localparam int NCNT_W          = $clog2(RESULT_CAP + 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3000);

    // event codes
    localparam logic [EV_W-1:0] EV_ON          = 3'd0;
    localparam logic [EV_W-1:0] EV_OFF         = 3'd1;
    localparam logic [EV_W-1:0] EV_ALREADY_ON  = 3'd2;
    localparam logic [EV_W-1:0] EV_ALREADY_OFF = 3'd3;
    localparam logic [EV_W-1:0] EV_OVERLOAD    = 3'd4;
    localparam logic [EV_W-1:0] EV_SHED        = 3'd5;
    localparam logic [EV_W-1:0] EV_KEPT        = 3'd6;
    localparam logic [EV_W-1:0] EV_UNRESOLVED  = 3'd7;

    // request opcodes
    localparam logic OP_ON  = 1'b0;
    localparam logic OP_OFF = 1'b1;

    // one stack entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [POWER_W-1:0] power;
        logic                      ess;
    } stack_entry_t;

    // power sign-extended by one bit
    function automatic logic signed [POWER_W:0] pwr_ext(input logic signed [POWER_W-1:0] p);
        pwr_ext = {p[POWER_W-1], p};
    endfunction

    // negated power, one bit wider so that the most negative value fits
    function automatic logic signed [POWER_W:0] pwr_neg(input logic signed [POWER_W-1:0] p);
        logic signed [POWER_W:0] e;
        e = {p[POWER_W-1], p};
        pwr_neg = -e;
    endfunction

    // total plus delta, clamped to the total range
    function automatic logic signed [TOTAL_W-1:0] sat_add(
        input logic signed [TOTAL_W-1:0] a,
        input logic signed [POWER_W:0]   d
    );
        logic signed [TOTAL_W:0] s;
        s = $signed({a[TOTAL_W-1], a}) + $signed({{(TOTAL_W - POWER_W){d[POWER_W]}}, d});
        if (s[TOTAL_W] != s[TOTAL_W-1]) begin
            sat_add = s[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            sat_add = s[TOTAL_W-1:0];
        end
    endfunction

endpackage

// ----- sv/lls_ram.sv -----
// ----------------------------------------------------------------------------
// lls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/lifo_load_shedder_unit.sv -----
// ----------------------------------------------------------------------------
// lifo_load_shedder_unit
// Each request searches the stack from the bottom, then switches the device on
// or off or reports it as already on or off; a removal closes the gap by moving
// the entries above it down. After a real switch, shedding scans from the newest
// entry keep essential entries and shed the first other one until the limit
// holds or only essentials remain. One request at a time; the next is taken
// once its last result sits in the output register. Reset clears count, total
// and control, sets the limit to 3000 and leaves the stack RAM as it is.
// ----------------------------------------------------------------------------
module lifo_load_shedder_unit #(
    parameter int DEVICES = lls_pkg::DEVICES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [lls_pkg::LIMIT_W-1:0]        cfg_wr_data,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [lls_pkg::ID_W-1:0]           s_device_id,
    input  logic signed [lls_pkg::POWER_W-1:0] s_device_power,
    input  logic                               s_essential,
    // event channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lls_pkg::EV_W-1:0]           m_event_res,
    output logic [lls_pkg::ID_W-1:0]           m_event_device,
    output logic signed [lls_pkg::TOTAL_W-1:0] m_power_total,
    output logic                               m_last
);

    import lls_pkg::*;

    localparam int AW  = $clog2(DEVICES);
    localparam int CW  = $clog2(DEVICES + 1);
    localparam int EW  = $bits(stack_entry_t);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_FIND_RD    = 4'd1;
    localparam logic [3:0] ST_FIND_CHK   = 4'd2;
    localparam logic [3:0] ST_DECIDE     = 4'd3;
    localparam logic [3:0] ST_SHIFT_TEST = 4'd4;
    localparam logic [3:0] ST_SHIFT_RD   = 4'd5;
    localparam logic [3:0] ST_SHIFT_WR   = 4'd6;
    localparam logic [3:0] ST_SHED_ENTRY = 4'd7;
    localparam logic [3:0] ST_SCAN_INIT  = 4'd8;
    localparam logic [3:0] ST_SCAN_RD    = 4'd9;
    localparam logic [3:0] ST_SCAN_CHK   = 4'd10;
    localparam logic [3:0] ST_SCAN_NEXT  = 4'd11;
    localparam logic [3:0] ST_EMIT       = 4'd12;
    localparam logic [3:0] ST_FLUSH      = 4'd13;

    // control state
    logic [3:0]                state_reg, state_next;
    logic [3:0]                after_reg, after_next;
    logic [CW-1:0]             count_reg, count_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [LIMIT_W-1:0]        limit_reg, limit_next;
    logic [NCNT_W-1:0]         nout_reg, nout_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic                      m_valid_reg, m_valid_next;

    // working registers
    logic                      op_reg, op_next;
    logic [ID_W-1:0]           dev_reg, dev_next;
    logic signed [POWER_W-1:0] pwr_reg, pwr_next;
    logic                      ess_reg, ess_next;
    logic                      found_reg, found_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             k_reg, k_next;
    logic [EV_W-1:0]           ecode_reg, ecode_next;
    logic [ID_W-1:0]           edev_reg, edev_next;

    // pending and output results
    logic [EV_W-1:0]           pend_res_reg, pend_res_next;
    logic [ID_W-1:0]           pend_dev_reg, pend_dev_next;
    logic signed [TOTAL_W-1:0] pend_tot_reg, pend_tot_next;
    logic [EV_W-1:0]           out_res_reg, out_res_next;
    logic [ID_W-1:0]           out_dev_reg, out_dev_next;
    logic signed [TOTAL_W-1:0] out_tot_reg, out_tot_next;
    logic                      out_last_reg, out_last_next;

    // stack memory
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    stack_entry_t              ram_wentry;
    logic [AW-1:0]             ram_raddr;
    logic [EW-1:0]             ram_rdata;
    stack_entry_t              rd_entry;

    logic                      out_free;
    logic [TOTAL_W-1:0]        total_mag;
    logic                      overload;
    logic                      s_fire;

    lls_ram #(
        .WIDTH (EW),
        .DEPTH (DEVICES)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = stack_entry_t'(ram_rdata);

    // handshake helpers
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // overload test on the magnitude of the total
    assign total_mag = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
    assign overload  = total_mag > TOTAL_W'(limit_reg);

    // next-state logic
    always_comb begin
        state_next      = state_reg;
        after_next      = after_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        limit_next      = cfg_wr_en ? cfg_wr_data : limit_reg;
        nout_next       = nout_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        op_next         = op_reg;
        dev_next        = dev_reg;
        pwr_next        = pwr_reg;
        ess_next        = ess_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        ecode_next      = ecode_reg;
        edev_next       = edev_reg;
        pend_res_next   = pend_res_reg;
        pend_dev_next   = pend_dev_reg;
        pend_tot_next   = pend_tot_reg;
        out_res_next    = out_res_reg;
        out_dev_next    = out_dev_reg;
        out_tot_next    = out_tot_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wentry      = '{id: dev_reg, power: pwr_reg, ess: ess_reg};
        ram_raddr       = idx_reg;

        case (state_reg)
            // take a request
            ST_IDLE: begin
                if (s_fire) begin
                    op_next    = s_opcode;
                    dev_next   = s_device_id;
                    pwr_next   = s_device_power;
                    ess_next   = s_essential;
                    nout_next  = '0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    if (32'(s_device_id) >= DEVICES) begin
                        state_next = ST_FLUSH;
                    end else if (count_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_FIND_RD;
                    end
                end
            end

            // search the stack from the bottom
            ST_FIND_RD: begin
                ram_raddr  = idx_reg;
                state_next = ST_FIND_CHK;
            end

            ST_FIND_CHK: begin
                if (rd_entry.id == dev_reg) begin
                    found_next = 1'b1;
                    k_next     = idx_reg;
                    pwr_next   = rd_entry.power;
                    state_next = ST_DECIDE;
                end else if ((CW'(idx_reg) + CW'(1)) < count_reg) begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_FIND_RD;
                end else begin
                    state_next = ST_DECIDE;
                end
            end

            // act on the request
            ST_DECIDE: begin
                edev_next = dev_reg;
                if (op_reg == OP_ON) begin
                    if (found_reg || count_reg == CW'(DEVICES)) begin
                        ecode_next = EV_ALREADY_ON;
                        after_next = ST_FLUSH;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        total_next = sat_add(total_reg, pwr_ext(pwr_reg));
                        ecode_next = EV_ON;
                        after_next = ST_SHED_ENTRY;
                    end
                    state_next = ST_EMIT;
                end else begin
                    if (found_reg) begin
                        total_next = sat_add(total_reg, pwr_neg(pwr_reg));
                        ecode_next = EV_OFF;
                        after_next = ST_SHED_ENTRY;
                        state_next = ST_SHIFT_TEST;
                    end else begin
                        ecode_next = EV_ALREADY_OFF;
                        after_next = ST_FLUSH;
                        state_next = ST_EMIT;
                    end
                end
            end

            // close the gap at entry k, then report the removal
            ST_SHIFT_TEST: begin
                if ((CW'(k_reg) + CW'(1)) < count_reg) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_EMIT;
                end
            end

            ST_SHIFT_RD: begin
                ram_raddr  = AW'(CW'(k_reg) + CW'(1));
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg;
                ram_wentry = rd_entry;
                k_next     = k_reg + AW'(1);
                state_next = ST_SHIFT_TEST;
            end

            // first overload test after a switch
            ST_SHED_ENTRY: begin
                if (overload) begin
                    ecode_next = EV_OVERLOAD;
                    edev_next  = dev_reg;
                    after_next = ST_SCAN_INIT;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_FLUSH;
                end
            end

            // start a scan from the newest entry
            ST_SCAN_INIT: begin
                if (!overload) begin
                    state_next = ST_FLUSH;
                end else if (count_reg == '0) begin
                    ecode_next = EV_UNRESOLVED;
                    edev_next  = dev_reg;
                    after_next = ST_FLUSH;
                    state_next = ST_EMIT;
                end else begin
                    idx_next   = AW'(count_reg - CW'(1));
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_RD: begin
                ram_raddr  = idx_reg;
                state_next = ST_SCAN_CHK;
            end

            // keep an essential device, shed the first other one
            ST_SCAN_CHK: begin
                edev_next = rd_entry.id;
                if (rd_entry.ess) begin
                    ecode_next = EV_KEPT;
                    after_next = ST_SCAN_NEXT;
                    state_next = ST_EMIT;
                end else begin
                    total_next = sat_add(total_reg, pwr_neg(rd_entry.power));
                    ecode_next = EV_SHED;
                    after_next = ST_SCAN_INIT;
                    k_next     = idx_reg;
                    state_next = ST_SHIFT_TEST;
                end
            end

            ST_SCAN_NEXT: begin
                if (idx_reg == '0) begin
                    ecode_next = EV_UNRESOLVED;
                    edev_next  = dev_reg;
                    after_next = ST_FLUSH;
                    state_next = ST_EMIT;
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            // queue one result unless the cap is reached; the older pending one moves to the output
            ST_EMIT: begin
                if (nout_reg == NCNT_W'(RESULT_CAP)) begin
                    state_next = after_reg;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        out_res_next  = pend_res_reg;
                        out_dev_next  = pend_dev_reg;
                        out_tot_next  = pend_tot_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_res_next   = ecode_reg;
                    pend_dev_next   = edev_reg;
                    pend_tot_next   = total_reg;
                    nout_next       = nout_reg + NCNT_W'(1);
                    state_next      = after_reg;
                end
            end

            // hand over the final result
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_res_next    = pend_res_reg;
                    out_dev_next    = pend_dev_reg;
                    out_tot_next    = pend_tot_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            after_reg      <= ST_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            limit_reg      <= LIMIT_RESET;
            nout_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            after_reg      <= after_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            limit_reg      <= limit_next;
            nout_reg       <= nout_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        dev_reg      <= dev_next;
        pwr_reg      <= pwr_next;
        ess_reg      <= ess_next;
        found_reg    <= found_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        ecode_reg    <= ecode_next;
        edev_reg     <= edev_next;
        pend_res_reg <= pend_res_next;
        pend_dev_reg <= pend_dev_next;
        pend_tot_reg <= pend_tot_next;
        out_res_reg  <= out_res_next;
        out_dev_reg  <= out_dev_next;
        out_tot_reg  <= out_tot_next;
        out_last_reg <= out_last_next;
    end

    // outputs
    assign m_valid        = m_valid_reg;
    assign m_event_res    = out_res_reg;
    assign m_event_device = out_dev_reg;
    assign m_power_total  = out_tot_reg;
    assign m_last         = out_last_reg;

endmodule

// ----- sv/lls_checker.sv -----
// ----------------------------------------------------------------------------
// lls_checker
// Port-level checks on the load shedder's handshakes and event ordering.
// ----------------------------------------------------------------------------
module lls_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [lls_pkg::EV_W-1:0]           m_event_res,
    input logic [lls_pkg::ID_W-1:0]           m_event_device,
    input logic signed [lls_pkg::TOTAL_W-1:0] m_power_total,
    input logic                               m_last
);

    import lls_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res)
            && $stable(m_event_device) && $stable(m_power_total) && $stable(m_last))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    // these events end a transaction's results
    a_final_events: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_ALREADY_ON || m_event_res == EV_ALREADY_OFF
            || m_event_res == EV_UNRESOLVED) |-> m_last)
        else $error("final event without last");

    // after a non-final result the next shown is a shedding event
    a_no_new_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !(m_valid && (m_event_res == EV_ON
            || m_event_res == EV_OFF || m_event_res == EV_ALREADY_ON
            || m_event_res == EV_ALREADY_OFF)))
        else $error("new request's result before last of previous");

endmodule

bind lifo_load_shedder_unit lls_checker u_lls_checker (.*);

// ----- tb/sv/tb_lifo_load_shedder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lifo_load_shedder_unit
// Self-checking bench for the LIFO load shedder. A queue-fed driver issues
// switch on/off requests. A scoreboard predicts the event transactions from
// its own copy of the device stack, running total and grid limit, and a
// monitor checks each event against it in order. The run covers directed
// corner cases and then random phases under several grid limits and
// handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_lifo_load_shedder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lls_pkg::*;

    localparam int DEVICES       = 8;
    localparam int CLK_HALF      = 5;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 42;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;
    localparam int WATCHDOG_NS   = 20_000_000;
    localparam int LIMIT_MAX     = (1 << LIMIT_W) - 1;
    localparam int POWER_MAX     = (1 << (POWER_W - 1)) - 1;
    localparam int POWER_MIN     = -(1 << (POWER_W - 1));
    localparam int TOTAL_MAX     = (1 << (TOTAL_W - 1)) - 1;
    localparam int TOTAL_MIN     = -(1 << (TOTAL_W - 1));

    // one switch request as driven on the request channel
    typedef struct packed {
        logic                      op;
        logic [ID_W-1:0]           id;
        logic signed [POWER_W-1:0] pwr;
        logic                      ess;
    } switch_req_t;

    // one event transaction as seen on the event channel
    typedef struct packed {
        logic [EV_W-1:0]           code;
        logic [ID_W-1:0]           dev;
        logic signed [TOTAL_W-1:0] total;
        logic                      last;
    } grid_event_t;

    // dut ports
    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      cfg_wr_en      = 1'b0;
    logic [LIMIT_W-1:0]        cfg_wr_data    = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic                      s_opcode       = 1'b0;
    logic [ID_W-1:0]           s_device_id    = '0;
    logic signed [POWER_W-1:0] s_device_power = '0;
    logic                      s_essential    = 1'b0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [EV_W-1:0]           m_event_res;
    logic [ID_W-1:0]           m_event_device;
    logic signed [TOTAL_W-1:0] m_power_total;
    logic                      m_last;

    // stimulus and scoreboard storage
    switch_req_t requests_q[$];
    grid_event_t events_due[$];
    grid_event_t burst_q[$];
    switch_req_t taken_req;
    switch_req_t next_req;
    grid_event_t got_ev;
    grid_event_t want_ev;
    int          fault_count    = 0;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;

    // shadow state of the shedder
    logic [ID_W-1:0] stk_id  [DEVICES];
    int              stk_pwr [DEVICES];
    logic            stk_ess [DEVICES];
    int              stk_cnt    = 0;
    int              grid_total = 0;
    int              grid_limit = int'(LIMIT_RESET);

    lifo_load_shedder_unit #(
        .DEVICES(DEVICES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_device_id    (s_device_id),
        .s_device_power (s_device_power),
        .s_essential    (s_essential),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_event_device (m_event_device),
        .m_power_total  (m_power_total),
        .m_last         (m_last)
    );

    // clock
    always #CLK_HALF aclk = ~aclk;

    // --------------------------------------------------------------------
    // event prediction
    // --------------------------------------------------------------------

    function automatic bit grid_overloaded();
        int mag;
        mag = (grid_total < 0) ? -grid_total : grid_total;
        return mag > grid_limit;
    endfunction

    // saturating update of the running total
    function automatic void add_power(int p);
        int t;
        t = grid_total + p;
        if (t > TOTAL_MAX) t = TOTAL_MAX;
        if (t < TOTAL_MIN) t = TOTAL_MIN;
        grid_total = t;
    endfunction

    // record an event with the current total, capped per request
    function automatic void note_event(logic [EV_W-1:0] code, logic [ID_W-1:0] dev);
        grid_event_t ev;
        if (burst_q.size() >= RESULT_CAP) return;
        ev.code  = code;
        ev.dev   = dev;
        ev.total = TOTAL_W'(grid_total);
        ev.last  = 1'b0;
        burst_q = {burst_q, ev};
    endfunction

    // drop entry i and close the gap
    function automatic void remove_entry(int i);
        for (int k = i; k + 1 < stk_cnt; k++) begin
            stk_id[k]  = stk_id[k + 1];
            stk_pwr[k] = stk_pwr[k + 1];
            stk_ess[k] = stk_ess[k + 1];
        end
        stk_cnt--;
    endfunction

    // repeated top-down scans until the limit holds or only essentials remain
    function automatic void shed_load(logic [ID_W-1:0] dev);
        int              i;
        logic [ID_W-1:0] victim;
        if (!grid_overloaded()) return;
        note_event(EV_OVERLOAD, dev);
        while (grid_overloaded()) begin
            i = stk_cnt - 1;
            while (i >= 0) begin
                if (!stk_ess[i]) break;
                note_event(EV_KEPT, stk_id[i]);
                i--;
            end
            if (i < 0) begin
                note_event(EV_UNRESOLVED, dev);
                return;
            end
            victim = stk_id[i];
            add_power(-stk_pwr[i]);
            remove_entry(i);
            note_event(EV_SHED, victim);
        end
    endfunction

    // expected events of one accepted request
    function automatic void predict_request(switch_req_t r);
        int          pos;
        grid_event_t tail;
        pos = -1;
        burst_q.delete();
        if (r.id >= DEVICES) return;
        for (int k = stk_cnt - 1; k >= 0; k--) begin
            if (stk_id[k] == r.id) pos = k;
        end
        if (r.op == OP_ON) begin
            if (pos >= 0 || stk_cnt >= DEVICES) begin
                note_event(EV_ALREADY_ON, r.id);
            end else begin
                stk_id[stk_cnt]  = r.id;
                stk_pwr[stk_cnt] = int'(r.pwr);
                stk_ess[stk_cnt] = r.ess;
                stk_cnt++;
                add_power(int'(r.pwr));
                note_event(EV_ON, r.id);
                shed_load(r.id);
            end
        end else if (pos < 0) begin
            note_event(EV_ALREADY_OFF, r.id);
        end else begin
            add_power(-stk_pwr[pos]);
            remove_entry(pos);
            note_event(EV_OFF, r.id);
            shed_load(r.id);
        end
        if (burst_q.size() == 0) return;
        tail = burst_q.pop_back();
        tail.last = 1'b1;
        burst_q = {burst_q, tail};
        events_due = {events_due, burst_q};
    endfunction

    // --------------------------------------------------------------------
    // stimulus helpers
    // --------------------------------------------------------------------

    function automatic void push_req(logic op, int id, int pwr, logic ess);
        switch_req_t r;
        if (pwr > POWER_MAX) pwr = POWER_MAX;
        if (pwr < POWER_MIN) pwr = POWER_MIN;
        r.op  = op;
        r.id  = ID_W'(id);
        r.pwr = POWER_W'(pwr);
        r.ess = ess;
        requests_q = {requests_q, r};
    endfunction

    // mostly powers scaled to the limit, some extremes, some fully random
    function automatic int pick_power(int lim);
        int                        span;
        int                        mag;
        int                        roll;
        logic signed [POWER_W-1:0] raw;
        roll = $urandom_range(99);
        span = (lim / 3 >= POWER_MAX) ? POWER_MAX : lim / 3 + 1;
        if (roll < 10) begin
            case ($urandom_range(3))
                0:       return POWER_MIN;
                1:       return POWER_MAX;
                2:       return 0;
                default: return -1;
            endcase
        end
        if (roll < 70) begin
            mag = $urandom_range(span);
            return $urandom_range(1) ? -mag : mag;
        end
        raw = POWER_W'($urandom);
        return int'(raw);
    endfunction

    function automatic void push_random_req(int lim);
        push_req(($urandom_range(99) < 60) ? OP_ON : OP_OFF, $urandom_range(DEVICES - 1),
                 pick_power(lim), $urandom_range(99) < 35);
    endfunction

    // clear all devices, fill seven under the limit, then switch on the eighth with a large power
    function automatic int push_fill_sequence(int lim);
        int order [DEVICES];
        int j;
        int tmp;
        int share;
        int mag;
        bit neg;
        for (int k = 0; k < DEVICES; k++) order[k] = k;
        for (int k = DEVICES - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < DEVICES; k++) begin
            push_req(OP_OFF, order[k], pick_power(lim), 1'($urandom_range(1)));
        end
        share = (lim / 8 > POWER_MAX) ? POWER_MAX : lim / 8;
        neg   = 1'($urandom_range(1));
        for (int k = 0; k < DEVICES - 1; k++) begin
            mag = $urandom_range(share);
            push_req(OP_ON, order[k], neg ? -mag : mag, 1'($urandom_range(1)));
        end
        mag = (lim < POWER_MAX) ? $urandom_range(POWER_MAX, lim) : POWER_MAX;
        push_req(OP_ON, order[DEVICES - 1], $urandom_range(1) ? -mag : mag,
                 1'($urandom_range(1)));
        return 2 * DEVICES;
    endfunction

    function automatic void set_idle_mode(int mode);
        case (mode)
            0: begin
                send_gap_pct   = 24;
                recv_stall_pct = 83;
            end
            1: begin
                send_gap_pct   = 83;
                recv_stall_pct = 24;
            end
            default: begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic int phase_limit(int ph);
        case (ph)
            0:       return LIMIT_MAX;
            1:       return 0;
            2:       return 3000;
            3:       return $urandom_range(LIMIT_MAX);
            4:       return 1;
            5:       return POWER_MAX;
            6:       return $urandom_range(200000);
            7:       return 0;
            default: return LIMIT_MAX;
        endcase
    endfunction

    // block idle: nothing queued, nothing in flight, all events seen
    task automatic wait_drained();
        @(negedge aclk);
        while (requests_q.size() != 0 || s_valid || events_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_limit(int value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LIMIT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grid_limit  = value;
    endtask

    task automatic flag_mismatch(string what, grid_event_t want, grid_event_t got);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%0t: %s: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                     $time, what, want.code, want.dev, $signed(want.total), want.last,
                     got.code, got.dev, $signed(got.total), got.last);
        end
    endtask

    // --------------------------------------------------------------------
    // request driver
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // accepted transaction feeds the predictor
            if (s_valid && s_ready) begin
                taken_req.op  = s_opcode;
                taken_req.id  = s_device_id;
                taken_req.pwr = s_device_power;
                taken_req.ess = s_essential;
                predict_request(taken_req);
            end
            // present the next request or idle
            if (!s_valid || s_ready) begin
                if (requests_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_req        = requests_q.pop_front();
                    s_valid        <= 1'b1;
                    s_opcode       <= next_req.op;
                    s_device_id    <= next_req.id;
                    s_device_power <= next_req.pwr;
                    s_essential    <= next_req.ess;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // event monitor
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_ev.code  = m_event_res;
                got_ev.dev   = m_event_device;
                got_ev.total = m_power_total;
                got_ev.last  = m_last;
                if (events_due.size() == 0) begin
                    flag_mismatch("event with none pending", '0, got_ev);
                end else begin
                    want_ev = events_due.pop_front();
                    if (want_ev !== got_ev) flag_mismatch("event mismatch", want_ev, got_ev);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // --------------------------------------------------------------------
    // test sequence
    // --------------------------------------------------------------------
    initial begin
        int made;
        set_idle_mode(0);

        // directed corner cases at the reset limit of 3000
        push_req(OP_ON,  0, 1000,      1'b0);  // plain switch on
        push_req(OP_ON,  0, 5,         1'b1);  // already on
        push_req(OP_OFF, 5, 0,         1'b0);  // already off
        push_req(OP_ON,  1, POWER_MAX, 1'b1);  // sheds device 0, then unresolved
        push_req(OP_OFF, 1, 0,         1'b0);  // back to zero
        push_req(OP_ON,  2, POWER_MIN, 1'b0);  // negative overload, sheds itself
        push_req(OP_ON,  3, -2000,     1'b1);
        push_req(OP_ON,  4, -1000,     1'b0);  // total exactly at the limit
        push_req(OP_ON,  5, -1,        1'b1);  // keeps 5, sheds 4
        push_req(OP_OFF, 3, 0,         1'b0);  // removal below the top
        push_req(OP_OFF, 5, 0,         1'b0);
        push_req(OP_ON,  6, 0,         1'b0);
        push_req(OP_ON,  7, 3000,      1'b0);
        push_req(OP_ON,  1, 1,         1'b1);  // keeps 1, sheds 7
        push_req(OP_OFF, 6, 0,         1'b0);
        push_req(OP_OFF, 1, 0,         1'b0);
        push_req(OP_OFF, 7, 0,         1'b1);  // shed device is now off

        // reset
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait_drained();

        // random phases, each under its own limit and stall pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            repeat (4) @(posedge aclk);
            set_idle_mode(ph / 3);
            write_limit(phase_limit(ph));
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(99) < 12) begin
                    made += push_fill_sequence(grid_limit);
                end else begin
                    push_random_req(grid_limit);
                    made++;
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0 && events_due.size() == 0) begin
            $display("lifo_load_shedder_unit test passed");
        end else begin
            $display("lifo_load_shedder_unit test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("lifo_load_shedder_unit test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lls_pkg.sv
sv/lls_ram.sv
sv/lifo_load_shedder_unit.sv
sv/lls_checker.sv
tb/sv/tb_lifo_load_shedder_unit.sv
